>>> hdl/bctad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bctad_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_HOUR        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_MINUTE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESET_HOUR       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESET_MINUTE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESET_SECOND     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_SECOND  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_HALF_PERIOD = 3'd6;
  localparam int unsigned CFG_DATA_W = 16;

  // mode codes
  localparam logic [1:0] MODE_COUNTDOWN = 2'd0;
  localparam logic [1:0] MODE_12H       = 2'd1;
  localparam logic [1:0] MODE_24H       = 2'd2;

  localparam logic [3:0] ALARM_TOGGLES = 4'd10;

  localparam logic [15:0] TPS_RESET  = 16'd1000;
  localparam logic [15:0] BLINK_RESET = 16'd500;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
  } time_t;

  // what the top level tells the time unit about this tick
  typedef struct packed {
    logic       press;
    logic       pulse;
    logic [1:0] mode;
  } time_ctrl_t;

  typedef struct packed {
    logic [6:0] segments;
    logic [5:0] digit_enable;
    logic [2:0] mode_leds;
    logic       alarm_out;
    time_t      tm;
    logic [1:0] current_mode;
  } result_t;

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // tens*10 + units
  function automatic logic [6:0] bcd_to_bin(input logic [2:0] t, input logic [3:0] u);
    return 7'(t) * 7'd10 + 7'(u);
  endfunction

  // v / 10 by reciprocal, exact for v < 80
  function automatic logic [2:0] div10(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[13:11];
  endfunction

endpackage

`default_nettype wire

>>> hdl/bctad_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bctad_in_if ();
  logic valid;
  logic ready;
  logic advance_held;
  logic mode_press;

  modport source (output valid, output advance_held, output mode_press, input ready);
  modport sink (input valid, input advance_held, input mode_press, output ready);
endinterface

`default_nettype wire

>>> hdl/bctad_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bctad_out_if ();
  logic       valid;
  logic       ready;
  logic [6:0] segments;
  logic [5:0] digit_enable;
  logic [2:0] mode_leds;
  logic       alarm_out;
  logic [1:0] hour_tens;
  logic [3:0] hour_units;
  logic [2:0] minute_tens;
  logic [3:0] minute_units;
  logic [2:0] second_tens;
  logic [3:0] second_units;
  logic [1:0] current_mode;

  modport source (output valid, output segments, output digit_enable, output mode_leds,
                  output alarm_out, output hour_tens, output hour_units,
                  output minute_tens, output minute_units, output second_tens,
                  output second_units, output current_mode, input ready);
  modport sink (input valid, input segments, input digit_enable, input mode_leds,
                input alarm_out, input hour_tens, input hour_units,
                input minute_tens, input minute_units, input second_tens,
                input second_units, input current_mode, output ready);
endinterface

`default_nettype wire

>>> hdl/bctad_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bctad_cfg_if import bctad_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/bctad_time.sv
`timescale 1ns / 1ps
`default_nettype none

// Next BCD time for one tick: mode load, countdown, 12/24-hour count, alarm match.
module bctad_time import bctad_pkg::*; (
  input  time_t      cur,
  input  time_ctrl_t ctrl,
  input  logic [4:0] preset_hour,
  input  logic [5:0] preset_minute,
  input  logic [5:0] preset_second,
  input  logic [4:0] alarm_hour,
  input  logic [5:0] alarm_minute,
  output time_t      nxt,
  output logic       alarm_match
);

  logic [6:0] h, m, s;
  logic [6:0] lh, lm, ls;
  logic [6:0] sh, sm, ss;
  logic [6:0] up_h, up_m, up_s;
  logic [6:0] dn_h, dn_m, dn_s;
  logic       load;
  logic       counting_up;
  logic       at_zero;
  logic [2:0] ht, mt, st;

  always_comb begin
    h = bcd_to_bin({1'b0, cur.hour_tens}, cur.hour_units);
    m = bcd_to_bin(cur.minute_tens, cur.minute_units);
    s = bcd_to_bin(cur.second_tens, cur.second_units);
    at_zero = (h == 7'd0) && (m == 7'd0) && (s == 7'd0);

    // countdown borrow chain
    dn_h = h;
    dn_m = m;
    dn_s = s;
    if (s != 7'd0) begin
      dn_s = s - 7'd1;
    end else begin
      dn_s = 7'd59;
      if (m != 7'd0) begin
        dn_m = m - 7'd1;
      end else begin
        dn_m = 7'd59;
        if (h != 7'd0) dn_h = h - 7'd1;
      end
    end

    // count-up carry chain
    up_h = h;
    up_m = m;
    up_s = s + 7'd1;
    if (up_s > 7'd59) begin
      up_s = 7'd0;
      up_m = m + 7'd1;
      if (up_m > 7'd59) begin
        up_m = 7'd0;
        up_h = h + 7'd1;
        if (ctrl.mode == MODE_12H) begin
          if (up_h > 7'd12) up_h = 7'd1;
        end else begin
          if (up_h > 7'd23) up_h = 7'd0;
        end
      end
    end

    load = 1'b0;
    counting_up = 1'b0;
    lh = h;
    lm = m;
    ls = s;
    if (ctrl.press) begin
      load = 1'b1;
      unique case (ctrl.mode)
        MODE_COUNTDOWN: begin
          lh = 7'd12; lm = 7'd0; ls = 7'd0;
        end
        MODE_12H: begin
          lh = 7'd0; lm = 7'd0; ls = 7'd0;
        end
        default: begin
          lh = 7'(preset_hour); lm = 7'(preset_minute); ls = 7'(preset_second);
        end
      endcase
    end else if (ctrl.pulse) begin
      unique case (ctrl.mode)
        MODE_COUNTDOWN: begin
          load = !at_zero;
          lh = dn_h; lm = dn_m; ls = dn_s;
        end
        MODE_12H, MODE_24H: begin
          load = 1'b1;
          counting_up = 1'b1;
          lh = up_h; lm = up_m; ls = up_s;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end

    // load saturates at 23:59:59
    sh = (lh > 7'd23) ? 7'd23 : lh;
    sm = (lm > 7'd59) ? 7'd59 : lm;
    ss = (ls > 7'd59) ? 7'd59 : ls;

    ht = div10(sh);
    mt = div10(sm);
    st = div10(ss);

    if (load) begin
      nxt.hour_tens    = ht[1:0];
      nxt.hour_units   = 4'(sh - 7'(ht) * 7'd10);
      nxt.minute_tens  = mt;
      nxt.minute_units = 4'(sm - 7'(mt) * 7'd10);
      nxt.second_tens  = st;
      nxt.second_units = 4'(ss - 7'(st) * 7'd10);
    end else begin
      nxt = cur;
    end

    alarm_match = counting_up && (sh == 7'(alarm_hour)) && (sm == 7'(alarm_minute))
                  && (ss == 7'd0);
  end

endmodule

`default_nettype wire

>>> hdl/bcd_clock_timer_alarm_display_top.sv
`timescale 1ns / 1ps
`default_nettype none

// A result is registered at the edge that accepts its tick item.
// Throughput: 1 item per cycle; one result register with ready pass-through lets an
// item enter every cycle while the sink keeps taking results.
// Reset (rst, synchronous): time 00:00:00, countdown mode, scan digit 0, alarm idle
// and low, registers back to their defaults; no result pending.
module bcd_clock_timer_alarm_display_top import bctad_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  bctad_in_if.sink     item_in,
  bctad_out_if.source  result_out,
  bctad_cfg_if.sink    cfg
);

  // configuration registers
  logic [4:0]  alarm_hour;
  logic [5:0]  alarm_minute;
  logic [4:0]  preset_hour;
  logic [5:0]  preset_minute;
  logic [5:0]  preset_second;
  logic [15:0] ticks_per_second;
  logic [15:0] blink_half_period;

  // block state
  logic [15:0] ms_count, ms_count_next;
  time_t       tm, tm_next;
  logic [1:0]  mode, mode_next;
  logic [2:0]  scan_index, scan_index_next;
  logic [3:0]  toggles_left, toggles_left_next;
  logic [15:0] blink_timer, blink_timer_next;
  logic        alarm_level, alarm_level_next;

  // output stage
  logic        out_valid;
  result_t     result, result_next;

  logic        accept;
  logic [15:0] tps_eff, bhp_eff;
  logic [15:0] ms_inc, blink_inc;
  logic        pulse;
  logic        alarm_match;
  time_ctrl_t  tctrl;
  logic [3:0]  scan_digit;
  logic [6:0]  segs;
  logic [5:0]  enable;
  logic [2:0]  leds;

  // Configuration writes are always taken; an index past the list is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_hour        <= 5'd0;
      alarm_minute      <= 6'd4;
      preset_hour       <= 5'd0;
      preset_minute     <= 6'd1;
      preset_second     <= 6'd0;
      ticks_per_second  <= TPS_RESET;
      blink_half_period <= BLINK_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_ALARM_HOUR:        alarm_hour        <= cfg.data[4:0];
        REG_ALARM_MINUTE:      alarm_minute      <= cfg.data[5:0];
        REG_PRESET_HOUR:       preset_hour       <= cfg.data[4:0];
        REG_PRESET_MINUTE:     preset_minute     <= cfg.data[5:0];
        REG_PRESET_SECOND:     preset_second     <= cfg.data[5:0];
        REG_TICKS_PER_SECOND:  ticks_per_second  <= cfg.data;
        REG_BLINK_HALF_PERIOD: blink_half_period <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input is taken whenever the result register is empty or being drained.
  assign item_in.ready = !out_valid || result_out.ready;
  assign accept = item_in.valid && item_in.ready;

  // a zero period acts as one
  assign tps_eff = (ticks_per_second == 16'd0) ? 16'd1 : ticks_per_second;
  assign bhp_eff = (blink_half_period == 16'd0) ? 16'd1 : blink_half_period;

  // Display scan: shows the digit held before this tick's time update.
  always_comb begin
    scan_digit = 4'd0;
    segs = 7'd0;
    enable = 6'd0;
    scan_index_next = 3'd0;
    unique case (scan_index)
      3'd0: scan_digit = tm.second_units;
      3'd1: scan_digit = {1'b0, tm.second_tens};
      3'd2: scan_digit = tm.minute_units;
      3'd3: scan_digit = {1'b0, tm.minute_tens};
      3'd4: scan_digit = tm.hour_units;
      3'd5: scan_digit = {2'b00, tm.hour_tens};
      default: scan_digit = 4'd0;
    endcase
    if (scan_index <= 3'd5) begin
      segs = seg_of(scan_digit);
      enable = 6'd1 << scan_index;
      scan_index_next = (scan_index == 3'd5) ? 3'd0 : scan_index + 3'd1;
    end
  end

  // Millisecond prescaler; advance forces a second step in the clock modes.
  always_comb begin
    ms_inc = ms_count + 16'd1;
    pulse = (ms_inc >= tps_eff) ||
            (item_in.advance_held && (mode == MODE_12H || mode == MODE_24H));
    if (item_in.mode_press) begin
      ms_count_next = 16'd0;
    end else if (mode == MODE_COUNTDOWN || mode == MODE_12H || mode == MODE_24H) begin
      ms_count_next = pulse ? 16'd0 : ms_inc;
    end else begin
      ms_count_next = ms_count;
    end
  end

  // Mode cycles countdown -> 12-hour -> 24-hour -> countdown on a press.
  always_comb begin
    mode_next = mode;
    if (item_in.mode_press) begin
      unique case (mode)
        MODE_COUNTDOWN: mode_next = MODE_12H;
        MODE_12H:       mode_next = MODE_24H;
        default:        mode_next = MODE_COUNTDOWN;
      endcase
    end
  end

  assign tctrl = '{press: item_in.mode_press, pulse: pulse, mode: mode};

  bctad_time u_time (
    .cur           (tm),
    .ctrl          (tctrl),
    .preset_hour   (preset_hour),
    .preset_minute (preset_minute),
    .preset_second (preset_second),
    .alarm_hour    (alarm_hour),
    .alarm_minute  (alarm_minute),
    .nxt           (tm_next),
    .alarm_match   (alarm_match)
  );

  // Alarm blinker: toggles on the old sequence first, then a fresh match
  // restarts the count while keeping the level.
  always_comb begin
    blink_inc = blink_timer + 16'd1;
    blink_timer_next = blink_timer;
    toggles_left_next = toggles_left;
    alarm_level_next = alarm_level;
    if (toggles_left != 4'd0) begin
      if (blink_inc >= bhp_eff) begin
        blink_timer_next = 16'd0;
        alarm_level_next = !alarm_level;
        toggles_left_next = toggles_left - 4'd1;
      end else begin
        blink_timer_next = blink_inc;
      end
    end
    if (alarm_match) begin
      toggles_left_next = ALARM_TOGGLES;
      blink_timer_next = 16'd0;
    end
  end

  always_comb begin
    unique case (mode_next)
      MODE_COUNTDOWN: leds = 3'b001;
      MODE_12H:       leds = 3'b010;
      MODE_24H:       leds = 3'b100;
      default:        leds = 3'b000;
    endcase
    result_next.segments     = segs;
    result_next.digit_enable = enable;
    result_next.mode_leds    = leds;
    result_next.alarm_out    = alarm_level_next;
    result_next.tm           = tm_next;
    result_next.current_mode = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_count     <= 16'd0;
      tm           <= '0;
      mode         <= MODE_COUNTDOWN;
      scan_index   <= 3'd0;
      toggles_left <= 4'd0;
      blink_timer  <= 16'd0;
      alarm_level  <= 1'b0;
    end else if (accept) begin
      ms_count     <= ms_count_next;
      tm           <= tm_next;
      mode         <= mode_next;
      scan_index   <= scan_index_next;
      toggles_left <= toggles_left_next;
      blink_timer  <= blink_timer_next;
      alarm_level  <= alarm_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.segments     = result.segments;
  assign result_out.digit_enable = result.digit_enable;
  assign result_out.mode_leds    = result.mode_leds;
  assign result_out.alarm_out    = result.alarm_out;
  assign result_out.hour_tens    = result.tm.hour_tens;
  assign result_out.hour_units   = result.tm.hour_units;
  assign result_out.minute_tens  = result.tm.minute_tens;
  assign result_out.minute_units = result.tm.minute_units;
  assign result_out.second_tens  = result.tm.second_tens;
  assign result_out.second_units = result.tm.second_units;
  assign result_out.current_mode = result.current_mode;

endmodule

`default_nettype wire

>>> tb/sv/clock_face_tb_pkg.sv
`timescale 1ns / 1ps

package clock_face_tb_pkg;
  import bctad_pkg::*;

  // seven-segment glyphs, bit0 = segment a
  localparam logic [6:0] GLYPH [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  class clock_face_tracker;
    // register copies
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic [4:0]  preset_hour;
    logic [5:0]  preset_minute;
    logic [5:0]  preset_second;
    logic [15:0] ticks_per_second;
    logic [15:0] blink_half_period;

    // block state
    logic [15:0] ms_count;
    time_t       face;
    logic [1:0]  mode;
    logic [2:0]  scan;
    logic [3:0]  toggles_left;
    logic [15:0] blink_timer;
    logic        alarm_level;

    result_t     due_faces[$];
    int          failures;

    function new();
      alarm_hour        = 5'd0;
      alarm_minute      = 6'd4;
      preset_hour       = 5'd0;
      preset_minute     = 6'd1;
      preset_second     = 6'd0;
      ticks_per_second  = TPS_RESET;
      blink_half_period = BLINK_RESET;
      ms_count          = '0;
      face              = '0;
      mode              = MODE_COUNTDOWN;
      scan              = '0;
      toggles_left      = '0;
      blink_timer       = '0;
      alarm_level       = 1'b0;
      failures          = 0;
    endfunction

    function int pending();
      return due_faces.size();
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ALARM_HOUR:        alarm_hour        = data[4:0];
        REG_ALARM_MINUTE:      alarm_minute      = data[5:0];
        REG_PRESET_HOUR:       preset_hour       = data[4:0];
        REG_PRESET_MINUTE:     preset_minute     = data[5:0];
        REG_PRESET_SECOND:     preset_second     = data[5:0];
        REG_TICKS_PER_SECOND:  ticks_per_second  = data;
        REG_BLINK_HALF_PERIOD: blink_half_period = data;
        default: ;
      endcase
    endfunction

    function int hours();
      return face.hour_tens * 10 + face.hour_units;
    endfunction

    function int minutes();
      return face.minute_tens * 10 + face.minute_units;
    endfunction

    function int seconds();
      return face.second_tens * 10 + face.second_units;
    endfunction

    // load with saturation: 23 hours, 59 minutes/seconds
    function void load(int h, int m, int s);
      if (h > 23) h = 23;
      if (m > 59) m = 59;
      if (s > 59) s = 59;
      face.hour_tens    = 2'(h / 10);
      face.hour_units   = 4'(h % 10);
      face.minute_tens  = 3'(m / 10);
      face.minute_units = 4'(m % 10);
      face.second_tens  = 3'(s / 10);
      face.second_units = 4'(s % 10);
    endfunction

    function logic [6:0] glyph(logic [3:0] d);
      return (d < 4'd10) ? GLYPH[d] : 7'h00;
    endfunction

    function string show(result_t r);
      return $sformatf("seg=%02h en=%02h leds=%03b alarm=%0b time=%0d%0d:%0d%0d:%0d%0d mode=%0d",
                       r.segments, r.digit_enable, r.mode_leds, r.alarm_out,
                       r.tm.hour_tens, r.tm.hour_units, r.tm.minute_tens,
                       r.tm.minute_units, r.tm.second_tens, r.tm.second_units,
                       r.current_mode);
    endfunction

    // one accepted tick: works out the face it must produce
    function void take_tick(bit adv, bit press);
      result_t    r;
      logic [3:0] d;
      int         h, m, s, tps, bhp;
      bit         sec_edge;
      r = '0;

      // scan uses the time held before this tick
      if (scan < 3'd6) begin
        case (scan)
          3'd0:    d = face.second_units;
          3'd1:    d = 4'(face.second_tens);
          3'd2:    d = face.minute_units;
          3'd3:    d = 4'(face.minute_tens);
          3'd4:    d = face.hour_units;
          default: d = 4'(face.hour_tens);
        endcase
        r.segments     = glyph(d);
        r.digit_enable = 6'b000001 << scan;
        scan           = (scan == 3'd5) ? 3'd0 : scan + 3'd1;
      end else begin
        scan = 3'd0;
      end

      tps = (ticks_per_second == 16'd0) ? 1 : int'(ticks_per_second);
      bhp = (blink_half_period == 16'd0) ? 1 : int'(blink_half_period);

      if (toggles_left != 4'd0) begin
        blink_timer = blink_timer + 16'd1;
        if (blink_timer >= bhp) begin
          blink_timer  = '0;
          alarm_level  = ~alarm_level;
          toggles_left = toggles_left - 4'd1;
        end
      end

      if (press) begin
        ms_count = '0;
        case (mode)
          MODE_COUNTDOWN: begin
            mode = MODE_12H;
            load(12, 0, 0);
          end
          MODE_12H: begin
            mode = MODE_24H;
            load(0, 0, 0);
          end
          default: begin
            mode = MODE_COUNTDOWN;
            load(preset_hour, preset_minute, preset_second);
          end
        endcase
      end else if (mode <= MODE_24H) begin
        ms_count = ms_count + 16'd1;
        sec_edge = (ms_count >= tps) || (mode != MODE_COUNTDOWN && adv);
        if (sec_edge) begin
          ms_count = '0;
          h = hours();
          m = minutes();
          s = seconds();
          if (mode == MODE_COUNTDOWN) begin
            if (h + m + s != 0) begin
              if (s > 0) begin
                s--;
              end else begin
                s = 59;
                if (m > 0) begin
                  m--;
                end else begin
                  m = 59;
                  if (h > 0) h--;
                end
              end
              load(h, m, s);
            end
          end else begin
            s++;
            if (s > 59) begin
              s = 0;
              m++;
              if (m > 59) begin
                m = 0;
                h++;
                if (mode == MODE_12H && h > 12) h = 1;
                else if (h > 23) h = 0;
              end
            end
            load(h, m, s);
            if (h == alarm_hour && m == alarm_minute && s == 0) begin
              toggles_left = ALARM_TOGGLES;
              blink_timer  = '0;
            end
          end
        end
      end

      r.mode_leds    = (mode <= MODE_24H) ? (3'b001 << mode) : 3'b000;
      r.alarm_out    = alarm_level;
      r.tm           = face;
      r.current_mode = mode;
      due_faces.push_back(r);
    endfunction

    function void compare_face(result_t got);
      result_t want;
      if (due_faces.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result with nothing due: %s", show(got));
        return;
      end
      want = due_faces.pop_front();
      if (got.segments !== want.segments || got.digit_enable !== want.digit_enable ||
          got.mode_leds !== want.mode_leds || got.alarm_out !== want.alarm_out ||
          got.tm.hour_tens !== want.tm.hour_tens ||
          got.tm.hour_units !== want.tm.hour_units ||
          got.tm.minute_tens !== want.tm.minute_tens ||
          got.tm.minute_units !== want.tm.minute_units ||
          got.tm.second_tens !== want.tm.second_tens ||
          got.tm.second_units !== want.tm.second_units ||
          got.current_mode !== want.current_mode) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch expected %s", show(want));
          $display("         actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

>>> tb/sv/bcd_clock_timer_alarm_display_top_tb.sv
`timescale 1ns / 1ps

module bcd_clock_timer_alarm_display_top_tb;
  import bctad_pkg::*;
  import clock_face_tb_pkg::*;

  // cycle limit for the hang guard, set well above what a full run needs
  localparam int LIMIT_CYCLES = 200_000;
  // index with no register behind it; a write must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  // receiver behavior per stretch
  typedef enum {RX_FLOW, RX_CHOPPY, RX_HOLD} rx_style_e;

  logic clk;
  logic rst;

  bctad_in_if  item_in ();
  bctad_out_if result_out ();
  bctad_cfg_if cfg ();

  clock_face_tracker face_sb;
  int                burst_left;

  bcd_clock_timer_alarm_display_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out),
    .cfg        (cfg)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: long free-flowing stretches, choppy stretches and short hard
  // stalls, so back-pressure lands on every phase of the clock's work.
  initial begin
    rx_style_e style;
    int        left;
    result_out.ready = 1'b0;
    left  = 0;
    style = RX_FLOW;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        style = rx_style_e'($urandom_range(0, 2));
        left  = (style == RX_HOLD) ? $urandom_range(1, 6) : $urandom_range(20, 120);
      end
      left--;
      case (style)
        RX_FLOW:   result_out.ready <= 1'b1;
        RX_CHOPPY: result_out.ready <= ($urandom_range(0, 3) != 0);
        default:   result_out.ready <= 1'b0;
      endcase
    end
  end

  // Monitor. Everything is sampled at the rising edge. The result is checked
  // before the tick of the same edge is predicted: since the result is registered,
  // the result seen at an edge always belongs to an earlier tick.
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (result_out.valid && result_out.ready) begin
        got.segments        = result_out.segments;
        got.digit_enable    = result_out.digit_enable;
        got.mode_leds       = result_out.mode_leds;
        got.alarm_out       = result_out.alarm_out;
        got.tm.hour_tens    = result_out.hour_tens;
        got.tm.hour_units   = result_out.hour_units;
        got.tm.minute_tens  = result_out.minute_tens;
        got.tm.minute_units = result_out.minute_units;
        got.tm.second_tens  = result_out.second_tens;
        got.tm.second_units = result_out.second_units;
        got.current_mode    = result_out.current_mode;
        face_sb.compare_face(got);
      end
      if (cfg.valid && cfg.ready) face_sb.set_reg(cfg.reg_index, cfg.data);
      if (item_in.valid && item_in.ready)
        face_sb.take_tick(item_in.advance_held, item_in.mode_press);
    end
  end

  // hang guard
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // One tick item. Called at a falling edge, returns at the falling edge after
  // acceptance. The sender runs in bursts; between bursts valid drops for a
  // random gap, and some bursts run long with no gap at all.
  task automatic send_tick(input bit adv, input bit press);
    int pick;
    int gap;
    if (burst_left == 0) begin
      pick       = $urandom_range(0, 9);
      gap        = (pick < 3) ? 0 : $urandom_range(1, 6);
      burst_left = (pick == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      if (gap != 0) begin
        item_in.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_in.valid        <= 1'b1;
    item_in.advance_held <= adv;
    item_in.mode_press   <= press;
    do @(posedge clk); while (!item_in.ready);
    @(negedge clk);
  endtask

  // n ticks; advance held adv_pct percent of the time, press_pm per mille presses
  task automatic run_ticks(input int n, input int adv_pct, input int press_pm);
    repeat (n) send_tick($urandom_range(0, 99) < adv_pct, $urandom_range(0, 999) < press_pm);
  endtask

  // press until the predicted mode is the one wanted
  task automatic goto_mode(input logic [1:0] target);
    while (face_sb.mode != target) send_tick($urandom_range(0, 1), 1'b1);
  endtask

  // stop sending and wait until every result due has come back;
  // always moves at least one falling edge so valid is not re-driven in the same step
  task automatic settle();
    item_in.valid <= 1'b0;
    do @(negedge clk); while (face_sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.data      <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  // period register choice: zero, tiny, extreme or random
  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd2;
      3:       return 16'd3;
      4:       return 16'hFFFF;
      5:       return 16'($urandom_range(4, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  // half the time, garbage above the register's width
  function automatic logic [15:0] with_junk(input int v, input int w);
    logic [15:0] keep;
    keep = 16'((1 << w) - 1);
    if ($urandom_range(0, 1)) return (16'($urandom) & ~keep) | (16'(v) & keep);
    return 16'(v);
  endfunction

  initial begin
    int cd_hour [4];
    int cd_min  [4];
    int cd_sec  [4];

    cd_hour              = '{0, 1, 23, 31};
    cd_min               = '{0, 0, 59, 63};
    cd_sec               = '{5, 0, 59, 63};
    face_sb              = new();
    burst_left           = 0;
    rst                  = 1'b1;
    item_in.valid        = 1'b0;
    item_in.advance_held = 1'b0;
    item_in.mode_press   = 1'b0;
    cfg.valid            = 1'b0;
    cfg.reg_index        = REG_ALARM_HOUR;
    cfg.data             = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed: default registers, 1000-tick seconds ----
    // countdown at 00:00:00 holds; advance ignored there
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    // press with advance held: into 12-hour at 12:00:00, press wins over counting
    send_tick(1'b1, 1'b1);
    repeat (3) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    // 24-hour loads 00:00:00
    send_tick(1'b0, 1'b1);
    repeat (2) send_tick(1'b1, 1'b0);
    // back to countdown: default preset 00:01:00
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    settle();
    // one tick per second: countdown starts moving
    write_reg(REG_TICKS_PER_SECOND, 16'd1);
    repeat (3) send_tick(1'b1, 1'b0);
    // through both clock modes once more
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // ---- countdown: reach zero and hold, borrows through hour, saturating preset ----
    for (int k = 0; k < 4; k++) begin
      settle();
      write_reg(REG_PRESET_HOUR, with_junk(cd_hour[k], 5));
      write_reg(REG_PRESET_MINUTE, with_junk(cd_min[k], 6));
      write_reg(REG_PRESET_SECOND, with_junk(cd_sec[k], 6));
      // 0 acts as 1; 2 and 3 exercise the prescaler
      write_reg(REG_TICKS_PER_SECOND, 16'(k));
      goto_mode(MODE_24H);
      send_tick($urandom_range(0, 1), 1'b1);
      run_ticks($urandom_range(20, 40), 50, 0);
    end

    // ---- 12-hour: alarm at 12:01:00 on the shown hour ----
    settle();
    write_reg(REG_ALARM_HOUR, 16'd12);
    write_reg(REG_ALARM_MINUTE, 16'd1);
    write_reg(REG_BLINK_HALF_PERIOD, 16'd2);
    write_reg(REG_TICKS_PER_SECOND, 16'd1);
    goto_mode(MODE_COUNTDOWN);
    send_tick(1'b0, 1'b1);
    run_ticks(100, 50, 0);

    // ---- 24-hour: alarm at 00:01:00, short random blink period ----
    settle();
    write_reg(REG_ALARM_HOUR, 16'd0);
    write_reg(REG_ALARM_MINUTE, 16'd1);
    write_reg(REG_BLINK_HALF_PERIOD, 16'($urandom_range(0, 8)));
    write_reg(REG_TICKS_PER_SECOND, 16'($urandom_range(0, 1)));
    goto_mode(MODE_12H);
    send_tick(1'b0, 1'b1);
    run_ticks(100, 50, 0);

    // ---- retrigger: second match while the toggle sequence still runs,
    //      mode presses in between do not stop it ----
    settle();
    write_reg(REG_ALARM_HOUR, 16'd0);
    write_reg(REG_ALARM_MINUTE, 16'd1);
    write_reg(REG_BLINK_HALF_PERIOD, 16'd30);
    write_reg(REG_TICKS_PER_SECOND, 16'd1);
    goto_mode(MODE_12H);
    send_tick(1'b0, 1'b1);
    run_ticks(65, 50, 0);
    repeat (3) send_tick($urandom_range(0, 1), 1'b1);
    run_ticks(70, 50, 0);
    run_ticks(80, 50, 0);

    // ---- zero blink period: toggle on every tick ----
    settle();
    write_reg(REG_BLINK_HALF_PERIOD, 16'd0);
    write_reg(REG_TICKS_PER_SECOND, 16'd0);
    goto_mode(MODE_12H);
    send_tick(1'b1, 1'b1);
    run_ticks(80, 70, 0);

    // ---- register extremes, alarm that can never match, spare index ----
    settle();
    write_reg(REG_ALARM_HOUR, 16'hFFFF);
    write_reg(REG_ALARM_MINUTE, 16'hFFFF);
    write_reg(REG_PRESET_HOUR, 16'd0);
    write_reg(REG_PRESET_MINUTE, 16'd0);
    write_reg(REG_PRESET_SECOND, 16'd0);
    write_reg(REG_TICKS_PER_SECOND, 16'hFFFF);
    write_reg(REG_BLINK_HALF_PERIOD, 16'hFFFF);
    write_reg(REG_SPARE, 16'($urandom));
    run_ticks(150, 30, 20);

    // ---- random phases: random registers, alarm times near where modes land ----
    repeat (3) begin
      settle();
      write_reg(REG_ALARM_HOUR, with_junk($urandom_range(0, 1) ?
                12 * $urandom_range(0, 1) : $urandom_range(0, 31), 5));
      write_reg(REG_ALARM_MINUTE, with_junk(($urandom_range(0, 3) != 0) ?
                $urandom_range(0, 2) : $urandom_range(0, 63), 6));
      write_reg(REG_PRESET_HOUR, with_junk($urandom_range(0, 31), 5));
      write_reg(REG_PRESET_MINUTE, with_junk($urandom_range(0, 63), 6));
      write_reg(REG_PRESET_SECOND, with_junk($urandom_range(0, 63), 6));
      write_reg(REG_TICKS_PER_SECOND, pick_period());
      write_reg(REG_BLINK_HALF_PERIOD, pick_period());
      goto_mode(2'($urandom_range(0, 2)));
      case ($urandom_range(0, 2))
        0:       run_ticks($urandom_range(50, 120), 0, 15);
        1:       run_ticks($urandom_range(50, 120), 50, 15);
        default: run_ticks($urandom_range(50, 120), 90, 15);
      endcase
    end

    // drain, then keep the clock running for anything stray to show up
    settle();
    repeat (8) @(posedge clk);
    if (face_sb.failures == 0 && face_sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/bctad_pkg.sv
hdl/bctad_in_if.sv
hdl/bctad_out_if.sv
hdl/bctad_cfg_if.sv
hdl/bctad_time.sv
hdl/bcd_clock_timer_alarm_display_top.sv
tb/sv/clock_face_tb_pkg.sv
tb/sv/bcd_clock_timer_alarm_display_top_tb.sv
